@@ src/wfad_pkg.sv @@
package wfad_pkg;

  // build constants
  localparam int TIME_BITS  = 48;
  localparam int COUNT_BITS = 24;

  // field and port widths
  localparam int ARRIVAL_W = 48;
  localparam int PKT_BITS_W = 20;
  localparam int BITS_W    = 40;
  localparam int GSUM_W    = 48;
  localparam int FIELD_CNT_W = 24;
  localparam int IN_W      = 72;
  localparam int OUT_W     = 144;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  // gap cutoff is five window lengths of a 32-bit window
  localparam int WIN_W  = 32;
  localparam int CUT_W  = WIN_W + 3;
  localparam int CMP_W  = (TIME_BITS > CUT_W) ? TIME_BITS : CUT_W;

  // band test widths
  localparam int PKT_V_W = (COUNT_BITS + 8 > 32) ? COUNT_BITS + 8 : 32;
  localparam int BIT_V_W = BITS_W + 8;
  localparam int HALF_W  = 24;
  localparam int PP_W    = HALF_W + COUNT_BITS;
  localparam int PROD_W  = 2 * HALF_W + COUNT_BITS;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic {
    KIND_PACKET = 1'b0,
    KIND_WEND   = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_GAP     = 2'd1,
    CAUSE_PACKETS = 2'd2,
    CAUSE_BITS    = 2'd3
  } cause_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_WINDOW_TICKS = 3'd1,
    REG_MEAN_PACKETS = 3'd2,
    REG_LIMIT_PACKETS = 3'd3,
    REG_MEAN_BITS    = 3'd4,
    REG_LIMIT_BITS   = 3'd5,
    REG_MEAN_GAP     = 3'd6,
    REG_LIMIT_GAP    = 3'd7
  } reg_idx_t;

  localparam logic [WIN_W-1:0] WINDOW_TICKS_RST = 32'd1000000;

  // live configuration seen by the datapath
  typedef struct packed {
    logic             enable;
    logic [CUT_W-1:0] cutoff;
    logic [31:0]      mean_pkt;
    logic [31:0]      lim_pkt;
    logic [47:0]      mean_bits;
    logic [47:0]      lim_bits;
    logic [47:0]      mean_gap;
    logic [47:0]      lim_gap;
  } cfg_t;

  // totals of one closed window
  typedef struct packed {
    count_t              pkts;
    logic [BITS_W-1:0]   bits;
    logic [GSUM_W-1:0]   gsum;
    count_t              gcnt;
  } cnts_t;

  // clamp a count to the 24-bit result field
  function automatic logic [FIELD_CNT_W-1:0] clamp_count(count_t v);
    logic [32:0] w;
    w = 33'(v);
    if (w > 33'h0_00FF_FFFF) begin
      return '1;
    end
    return FIELD_CNT_W'(v);
  endfunction

endpackage

@@ src/wfad_cfg.sv @@
module wfad_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wen,
  input  logic [wfad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wfad_pkg::CFG_W-1:0]     cfg_wdata,
  output wfad_pkg::cfg_t                 cfg
);
  import wfad_pkg::*;

  cfg_t cfg_r;
  logic [WIN_W-1:0] win;

  assign win = cfg_wdata[WIN_W-1:0];
  assign cfg = cfg_r;

  // register file, cutoff kept as five times the window length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable    <= 1'b0;
      cfg_r.cutoff    <= CUT_W'({WINDOW_TICKS_RST, 2'b00}) + CUT_W'(WINDOW_TICKS_RST);
      cfg_r.mean_pkt  <= '0;
      cfg_r.lim_pkt   <= '0;
      cfg_r.mean_bits <= '0;
      cfg_r.lim_bits  <= '0;
      cfg_r.mean_gap  <= '0;
      cfg_r.lim_gap   <= '0;
    end else if (cfg_wen) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ENABLE:        cfg_r.enable    <= cfg_wdata[0];
        REG_WINDOW_TICKS:  cfg_r.cutoff    <= CUT_W'({win, 2'b00}) + CUT_W'(win);
        REG_MEAN_PACKETS:  cfg_r.mean_pkt  <= cfg_wdata[31:0];
        REG_LIMIT_PACKETS: cfg_r.lim_pkt   <= cfg_wdata[31:0];
        REG_MEAN_BITS:     cfg_r.mean_bits <= cfg_wdata;
        REG_LIMIT_BITS:    cfg_r.lim_bits  <= cfg_wdata;
        REG_MEAN_GAP:      cfg_r.mean_gap  <= cfg_wdata;
        REG_LIMIT_GAP:     cfg_r.lim_gap   <= cfg_wdata;
        default:           cfg_r.enable    <= cfg_r.enable;
      endcase
    end
  end

endmodule

@@ src/wfad_accum.sv @@
module wfad_accum (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wfad_pkg::cfg_t            cfg,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [wfad_pkg::IN_W-1:0] in_tdata,  // arrival_time, packet_bits, pad
  input  logic                      in_tuser,  // kind
  output logic                      snap_valid,
  output wfad_pkg::cnts_t           snap,
  input  logic                      snap_ready
);
  import wfad_pkg::*;

  // input register
  logic                  v0_r;
  kind_t                 kind0_r;
  time_t                 t0_r;
  logic [PKT_BITS_W-1:0] bits0_r;

  // window state
  count_t              pkts_r, pkts_nxt;
  logic [BITS_W-1:0]   bits_r, bits_nxt;
  logic [GSUM_W-1:0]   gsum_r, gsum_nxt;
  count_t              gcnt_r, gcnt_nxt;
  time_t               prev_r;
  logic                seen_r;

  logic                s0_free;
  logic                take;
  time_t               gap;
  logic [CMP_W-1:0]    gap_ext;
  logic                gap_ok;
  logic [COUNT_BITS:0] psum, gcsum;
  logic [BITS_W:0]     bsum;
  logic [GSUM_W:0]     gssum;

  // a window end waits here until the evaluation pipe takes it
  assign snap_valid = v0_r && (kind0_r == KIND_WEND) && cfg.enable;
  assign s0_free    = !snap_valid || snap_ready;
  assign in_tready  = s0_free;
  assign take       = v0_r && cfg.enable && s0_free;
  assign snap       = '{pkts: pkts_r, bits: bits_r, gsum: gsum_r, gcnt: gcnt_r};

  // gap to the previous arrival, counted only up to the cutoff
  assign gap     = t0_r - prev_r;
  assign gap_ext = CMP_W'(gap);
  assign gap_ok  = seen_r && (gap_ext <= CMP_W'(cfg.cutoff));

  // saturating window sums
  always_comb begin
    psum  = {1'b0, pkts_r} + (COUNT_BITS+1)'(1);
    bsum  = {1'b0, bits_r} + (BITS_W+1)'(bits0_r);
    gssum = {1'b0, gsum_r} + (GSUM_W+1)'(gap_ext[CUT_W-1:0]);
    gcsum = {1'b0, gcnt_r} + (COUNT_BITS+1)'(1);
    pkts_nxt = psum[COUNT_BITS] ? '1 : psum[COUNT_BITS-1:0];
    bits_nxt = bsum[BITS_W] ? '1 : bsum[BITS_W-1:0];
    gsum_nxt = gsum_r;
    gcnt_nxt = gcnt_r;
    if (gap_ok) begin
      gsum_nxt = gssum[GSUM_W] ? '1 : gssum[GSUM_W-1:0];
      gcnt_nxt = gcsum[COUNT_BITS] ? '1 : gcsum[COUNT_BITS-1:0];
    end
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      pkts_r <= '0;
      bits_r <= '0;
      gsum_r <= '0;
      gcnt_r <= '0;
      prev_r <= '0;
      seen_r <= 1'b0;
    end else begin
      if (s0_free) begin
        v0_r <= in_tvalid;
      end
      if (take) begin
        if (kind0_r == KIND_PACKET) begin
          pkts_r <= pkts_nxt;
          bits_r <= bits_nxt;
          gsum_r <= gsum_nxt;
          gcnt_r <= gcnt_nxt;
          prev_r <= t0_r;
          seen_r <= 1'b1;
        end else begin
          pkts_r <= '0;
          bits_r <= '0;
          gsum_r <= '0;
          gcnt_r <= '0;
        end
      end
    end
  end

  // input payload
  always_ff @(posedge clk) begin
    if (s0_free) begin
      kind0_r <= kind_t'(in_tuser);
      t0_r    <= TIME_BITS'(in_tdata[ARRIVAL_W-1:0]);
      bits0_r <= in_tdata[ARRIVAL_W +: PKT_BITS_W];
    end
  end

endmodule

@@ src/wfad_eval.sv @@
module wfad_eval (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wfad_pkg::cfg_t             cfg,
  input  logic                       snap_valid,
  input  wfad_pkg::cnts_t            snap,
  output logic                       snap_ready,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // alarm, cause, packet_count, bit_count, gap_total, gap_count, pad
  output logic [wfad_pkg::OUT_W-1:0] out_tdata
);
  import wfad_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic adv1, adv2, adv3, adv4, adv5;

  cnts_t c1_r, c2_r, c3_r, c4_r, c5_r;

  // stage 2: partial products and band distances
  logic [PP_W-1:0]    pm_lo_r, pm_hi_r, pl_lo_r, pl_hi_r;
  logic [PKT_V_W-1:0] pkt_d_r, pkt_v, pkt_m;
  logic [BIT_V_W-1:0] bit_d_r, bit_v, bit_m;

  // stage 3: full products and band flags
  logic [PROD_W-1:0] lhs3_r, rhs3_r, lim3_r;
  logic              pkt_out3_r, bit_out3_r;

  // stage 4: gap distance
  logic [PROD_W-1:0] gd4_r, lim4_r;
  logic              pkt_out4_r, bit_out4_r;

  // output register
  logic   alarm_r;
  cause_t cause_r, cause_nxt;
  logic   gap_out;

  // each stage moves when the next one is free or moving
  assign adv5       = !out_valid_r || out_tready;
  assign adv4       = !v4_r || adv5;
  assign adv3       = !v3_r || adv4;
  assign adv2       = !v2_r || adv3;
  assign adv1       = !v1_r || adv2;
  assign snap_ready = adv1;

  assign pkt_v = PKT_V_W'({c1_r.pkts, 8'h00});
  assign pkt_m = PKT_V_W'(cfg.mean_pkt);
  assign bit_v = {c1_r.bits, 8'h00};
  assign bit_m = cfg.mean_bits;

  // final gap test and cause priority
  always_comb begin
    gap_out = (c4_r.gcnt != '0) && (gd4_r > lim4_r);
    priority if (c4_r.pkts == '0) begin
      cause_nxt = CAUSE_NONE;
    end else if (gap_out) begin
      cause_nxt = CAUSE_GAP;
    end else if (pkt_out4_r) begin
      cause_nxt = CAUSE_PACKETS;
    end else if (bit_out4_r) begin
      cause_nxt = CAUSE_BITS;
    end else begin
      cause_nxt = CAUSE_NONE;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= snap_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) out_valid_r <= v4_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv1) begin
      c1_r <= snap;
    end
    if (adv2) begin
      c2_r    <= c1_r;
      pm_lo_r <= PP_W'(cfg.mean_gap[HALF_W-1:0]) * PP_W'(c1_r.gcnt);
      pm_hi_r <= PP_W'(cfg.mean_gap[2*HALF_W-1:HALF_W]) * PP_W'(c1_r.gcnt);
      pl_lo_r <= PP_W'(cfg.lim_gap[HALF_W-1:0]) * PP_W'(c1_r.gcnt);
      pl_hi_r <= PP_W'(cfg.lim_gap[2*HALF_W-1:HALF_W]) * PP_W'(c1_r.gcnt);
      pkt_d_r <= (pkt_v >= pkt_m) ? pkt_v - pkt_m : pkt_m - pkt_v;
      bit_d_r <= (bit_v >= bit_m) ? bit_v - bit_m : bit_m - bit_v;
    end
    if (adv3) begin
      c3_r       <= c2_r;
      lhs3_r     <= PROD_W'({c2_r.gsum, 8'h00});
      rhs3_r     <= (PROD_W'(pm_hi_r) << HALF_W) + PROD_W'(pm_lo_r);
      lim3_r     <= (PROD_W'(pl_hi_r) << HALF_W) + PROD_W'(pl_lo_r);
      pkt_out3_r <= pkt_d_r > PKT_V_W'(cfg.lim_pkt);
      bit_out3_r <= bit_d_r > cfg.lim_bits;
    end
    if (adv4) begin
      c4_r       <= c3_r;
      gd4_r      <= (lhs3_r >= rhs3_r) ? lhs3_r - rhs3_r : rhs3_r - lhs3_r;
      lim4_r     <= lim3_r;
      pkt_out4_r <= pkt_out3_r;
      bit_out4_r <= bit_out3_r;
    end
    if (adv5) begin
      c5_r    <= c4_r;
      cause_r <= cause_nxt;
      alarm_r <= cause_nxt != CAUSE_NONE;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, clamp_count(c5_r.gcnt), c5_r.gsum, c5_r.bits,
                       clamp_count(c5_r.pkts), cause_r, alarm_r};

endmodule

@@ src/windowed_flow_anomaly_detector.sv @@
// Windowed flow anomaly detector. Packet beats (in_tuser low) carry an arrival
// time and a size in bits; a window-end beat (in_tuser high) closes the window
// and, while enabled, yields one result beat with the window totals and an
// alarm when the packet count, bit count or mean inter-arrival gap falls
// outside its configured Q8 band (cause priority gap, packets, bits). The
// block takes one beat per clock: packets update the window sums in the cycle
// after they are accepted, and a window end passes from the input register to
// out_tdata through a five-stage evaluation pipe whose depth is set by the
// split 48 x 24 bit gap products. Results that wait on out_tready hold the
// pipe; packet beats keep flowing unless a window end is stuck at the input
// register behind a full pipe. Configuration writes take effect at once and
// should only be made while no beat is in flight.
module windowed_flow_anomaly_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wen,
  input  logic [wfad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wfad_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [wfad_pkg::IN_W-1:0]      in_tdata,   // arrival_time, packet_bits, pad
  input  logic                           in_tuser,   // kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // alarm, cause, packet_count, bit_count, gap_total, gap_count, pad
  output logic [wfad_pkg::OUT_W-1:0]     out_tdata
);
  import wfad_pkg::*;

  cfg_t  cfg;
  cnts_t snap;
  logic  snap_valid;
  logic  snap_ready;

  // configuration registers
  wfad_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register and window sums
  wfad_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready)
  );

  // band tests and result register
  wfad_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ src/wfad_checker.sv @@
module wfad_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [wfad_pkg::OUT_W-1:0] out_tdata
);
  import wfad_pkg::*;

  logic                   alarm;
  logic [1:0]             cause;
  logic [FIELD_CNT_W-1:0] pkt_cnt, gap_cnt;
  logic [GSUM_W-1:0]      gap_tot;

  assign alarm   = out_tdata[0];
  assign cause   = out_tdata[2:1];
  assign pkt_cnt = out_tdata[26:3];
  assign gap_tot = out_tdata[114:67];
  assign gap_cnt = out_tdata[138:115];

  // reset empties the result register
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid after reset");

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // alarm flag agrees with cause, and an empty window never alarms
  a_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (alarm == (cause != CAUSE_NONE)) && (pkt_cnt != '0 || !alarm))
    else $error("alarm and cause disagree");

  // gaps only come from packets after the first one
  a_gaps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (gap_cnt <= pkt_cnt) && (gap_cnt != '0 || gap_tot == '0))
    else $error("gap totals inconsistent with packet count");

endmodule

bind windowed_flow_anomaly_detector wfad_checker u_wfad_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
